### rtl/core/mmvs_pkg.sv
// Shared types and constants for the min/max value store.
// Used by mmvs_ram, mmvs_ctrl and min_max_value_store_core.
package mmvs_pkg;

	localparam int DEPTH    = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT = OP_W'(0);
	localparam logic [OP_W-1:0] OP_QMIN   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_RMIN   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_QMAX   = OP_W'(3);
	localparam logic [OP_W-1:0] OP_RMAX   = OP_W'(4);

	localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		logic [STATUS_W-1:0]       status;
		logic [ENTRY_W-1:0]        entry_count;
	} out_word_t;

	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               we;
		logic [ADDR_W-1:0]  wr_addr;
		logic [VALUE_W-1:0] wr_data;
	} mem_req_t;

endpackage

### rtl/core/mmvs_ram.sv
// Value memory: one write port, one read port, registered read data.
// Depends on mmvs_pkg for depth, widths and the request struct.
module mmvs_ram import mmvs_pkg::*; (
	input  logic               clk,
	input  mem_req_t           req,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### rtl/core/mmvs_ctrl.sv
// Request sequencer: insert, extreme scan over memory and compaction after removal.
// Depends on mmvs_pkg; drives mmvs_ram through a mem_req_t.
module mmvs_ctrl import mmvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_data,
	output logic               res_valid,
	output out_word_t          res_data,
	input  logic               res_take,
	output mem_req_t           mem_req,
	input  logic [VALUE_W-1:0] rd_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_DONE} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [ADDR_W-1:0]         rcv_q;
	logic [ADDR_W-1:0]         best_idx_q;
	logic [ADDR_W-1:0]         sh_q;
	logic signed [VALUE_W-1:0] best_q;
	logic                      want_max_q;
	logic                      remove_q;
	logic signed [VALUE_W-1:0] res_value_q;
	logic [STATUS_W-1:0]       res_status_q;

	logic                      in_fire;
	logic                      is_search;
	logic [CNT_W-1:0]          last_c;
	logic                      take_new;
	logic signed [VALUE_W-1:0] best_c;
	logic [ADDR_W-1:0]         best_idx_c;
	logic                      scan_last;
	logic                      need_shift;
	logic                      shift_more;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign is_search = (in_data.op == OP_QMIN) || (in_data.op == OP_RMIN) ||
	                   (in_data.op == OP_QMAX) || (in_data.op == OP_RMAX);
	assign last_c    = cnt_q - CNT_W'(1);

	assign take_new   = (rcv_q == '0) ||
	                    (want_max_q ? ($signed(rd_data) > best_q) : ($signed(rd_data) < best_q));
	assign best_c     = take_new ? $signed(rd_data) : best_q;
	assign best_idx_c = take_new ? rcv_q : best_idx_q;
	assign scan_last  = (CNT_W'(rcv_q) == last_c);
	assign need_shift = (CNT_W'(best_idx_c) != last_c);
	assign shift_more = ((CNT_W + 1)'(sh_q) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(cnt_q);

	assign res_valid             = (state_q == ST_DONE);
	assign res_data.result_value = res_value_q;
	assign res_data.status       = res_status_q;
	assign res_data.entry_count  = ENTRY_W'(cnt_q);

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.op == OP_INSERT) begin
						mem_req.we      = (cnt_q < CNT_W'(DEPTH));
						mem_req.wr_addr = ADDR_W'(cnt_q);
						mem_req.wr_data = in_data.value;
					end else if (is_search && (cnt_q != '0)) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = '0;
					end
				end
			end
			ST_SCAN: begin
				if (!scan_last) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = rcv_q + ADDR_W'(1);
				end else if (remove_q && need_shift) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = best_idx_c + ADDR_W'(1);
				end
			end
			ST_SHIFT: begin
				mem_req.we      = 1'b1;
				mem_req.wr_addr = sh_q;
				mem_req.wr_data = rd_data;
				if (shift_more) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = sh_q + ADDR_W'(2);
				end
			end
			ST_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_value_q  <= '0;
						res_status_q <= ST_OK;
						want_max_q   <= (in_data.op == OP_QMAX) || (in_data.op == OP_RMAX);
						remove_q     <= (in_data.op == OP_RMIN) || (in_data.op == OP_RMAX);
						rcv_q        <= '0;
						state_q      <= ST_DONE;
						if (in_data.op == OP_INSERT) begin
							res_value_q <= in_data.value;
							if (cnt_q >= CNT_W'(DEPTH)) begin
								res_status_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else if (is_search) begin
							if (cnt_q == '0) begin
								res_status_q <= ST_EMPTY;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					best_q     <= best_c;
					best_idx_q <= best_idx_c;
					rcv_q      <= rcv_q + ADDR_W'(1);
					if (scan_last) begin
						res_value_q <= best_c;
						state_q     <= ST_DONE;
						if (remove_q) begin
							if (need_shift) begin
								sh_q    <= best_idx_c;
								state_q <= ST_SHIFT;
							end else begin
								cnt_q <= last_c;
							end
						end
					end
				end
				ST_SHIFT: begin
					sh_q <= sh_q + ADDR_W'(1);
					if (!shift_more) begin
						cnt_q   <= last_c;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.rd_en) |-> (mem_req.wr_addr < mem_req.rd_addr))
		else $error("write overtakes pending read");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
		else $error("count moved by more than one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cnt_q <= CNT_W'(DEPTH)))
		else $error("count beyond depth");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status_q == ST_EMPTY)) |-> (cnt_q == '0))
		else $error("empty reported with entries held");

	a_shift_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (($past(state_q) == ST_SCAN) || ($past(state_q) == ST_SHIFT)))
		else $error("compaction entered without scan");

endmodule

### rtl/core/min_max_value_store_core.sv
// Top level of the min/max value store: sequencer, value memory and output register.
// Depends on mmvs_pkg, mmvs_ram and mmvs_ctrl.
//
//  channel  signals                          word
//  request  in_valid, in_ready, in_data      in_word_t  (op, value)
//  result   out_valid, out_ready, out_data   out_word_t (result_value, status, entry_count)
//
// Insert, empty, full and unused codes go from acceptance straight to the result state.
// For query and remove, the memory read port is walked one entry a cycle for the scan,
// and for remove then again from the removed entry upward to close the gap.
// Reset clears the count, the sequencer state and the output valid only; no memory clearing pass.
// A finished word waits in the output register while the next request is taken.
module min_max_value_store_core import mmvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	mem_req_t           mem_req;
	logic [VALUE_W-1:0] rd_data;
	logic               res_valid;
	out_word_t          res_data;
	logic               res_take;
	logic               out_valid_q;
	out_word_t          out_q;

	mmvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (res_take),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	mmvs_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign res_take  = res_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res_data;
		end
	end

endmodule

### bench/min_max_value_store_core_tb.sv
// Self-checking bench for min_max_value_store_core: a table of requests, then random traffic.
// Results are checked against a shadow store kept in arrival order in this file.
// Depends on mmvs_pkg and the RTL of the core.
module min_max_value_store_core_tb;
	import mmvs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OP_SPARE_LO = int'(OP_RMAX) + 1;
	localparam int OP_SPARE_HI = (1 << OP_W) - 1;
	localparam int RANDOM_WORDS = 950;
	localparam int HOLD_AT = 450;
	localparam int HOLD_CYCLES = 150;
	localparam int PAUSE_AT = 700;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		in_word_t  req;
		bit        typed;
		out_word_t want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	logic signed [VALUE_W-1:0] shadow_vals[$];
	out_word_t                 pending_results[$];
	plan_row_t                 plan[$];
	int                        mismatch_count = 0;
	int                        results_seen = 0;
	bit                        no_idle = 1'b0;

	min_max_value_store_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic out_word_t apply_request(input in_word_t w);
		out_word_t r;
		int        pick;
		bit        want_max;
		r = '0;
		r.status = ST_OK;
		want_max = (w.op == OP_QMAX) || (w.op == OP_RMAX);
		case (w.op)
			OP_INSERT: begin
				r.result_value = w.value;
				if (shadow_vals.size() >= DEPTH)
					r.status = ST_FULL;
				else
					shadow_vals.push_back(w.value);
			end
			OP_QMIN, OP_RMIN, OP_QMAX, OP_RMAX: begin
				if (shadow_vals.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pick = 0;
					for (int i = 1; i < shadow_vals.size(); i++) begin
						if (want_max ? (shadow_vals[i] > shadow_vals[pick])
								: (shadow_vals[i] < shadow_vals[pick]))
							pick = i;
					end
					r.result_value = shadow_vals[pick];
					if (w.op == OP_RMIN || w.op == OP_RMAX)
						shadow_vals.delete(pick);
				end
			end
			default: ;
		endcase
		r.entry_count = ENTRY_W'(shadow_vals.size());
		return r;
	endfunction

	function automatic plan_row_t plan_row(input logic [OP_W-1:0] op,
			input logic signed [VALUE_W-1:0] val, input bit typed,
			input logic signed [VALUE_W-1:0] rv, input logic [STATUS_W-1:0] st,
			input int cnt);
		plan_row_t p;
		p.req.op = op;
		p.req.value = val;
		p.typed = typed;
		p.want.result_value = rv;
		p.want.status = st;
		p.want.entry_count = ENTRY_W'(cnt);
		return p;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic in_word_t random_request(input int insert_pct);
		in_word_t w;
		int       roll;
		roll = $urandom_range(0, 99);
		w.value = pick_value();
		if (roll < insert_pct)
			w.op = OP_INSERT;
		else if (roll < 96)
			w.op = OP_W'($urandom_range(int'(OP_QMIN), int'(OP_RMAX)));
		else
			w.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t pred;
		if (!no_idle && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = apply_request(w);
		pending_results.push_back(typed ? want : pred);
	endtask

	function automatic void report(input string what, input out_word_t want,
			input out_word_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
				$time, what, want.result_value, want.status, want.entry_count,
				got.result_value, got.status, got.entry_count);
	endfunction

	// result side: check, then choose ready for the next cycle
	initial begin
		out_word_t want;
		int        hold_left;
		bit        held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report("word with nothing pending", '0, out_data);
				end else begin
					want = pending_results.pop_front();
					if (out_data.result_value !== want.result_value
							|| out_data.status !== want.status
							|| out_data.entry_count !== want.entry_count)
						report("mismatch", want, out_data);
				end
			end
			if (results_seen == HOLD_AT && !held) begin
				hold_left = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		wait (arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("min_max_value_store_core_tb failed");
		$finish;
	end

	initial begin
		logic signed [VALUE_W-1:0] fill_vals[16];
		int                        insert_pct;
		fill_vals = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh55555555, 32'shAAAAAAAA, 42, -42, 32'sh7FFFFFFE, 32'sh80000001,
			1000, -1000, 7};

		plan.push_back(plan_row(OP_QMIN, 32'sh11111111, 1'b1, 0, ST_EMPTY, 0));
		plan.push_back(plan_row(OP_RMIN, 0, 1'b1, 0, ST_EMPTY, 0));
		plan.push_back(plan_row(OP_QMAX, -1, 1'b1, 0, ST_EMPTY, 0));
		plan.push_back(plan_row(OP_RMAX, 0, 1'b1, 0, ST_EMPTY, 0));
		plan.push_back(plan_row(OP_W'(OP_SPARE_HI), 32'sh5A5A5A5A, 1'b1, 0, ST_OK, 0));
		for (int i = 0; i < DEPTH; i++)
			plan.push_back(plan_row(OP_INSERT, fill_vals[i], 1'b1, fill_vals[i], ST_OK, i + 1));
		plan.push_back(plan_row(OP_INSERT, 32'sh12345678, 1'b1, 32'sh12345678, ST_FULL, DEPTH));
		plan.push_back(plan_row(OP_QMIN, 0, 1'b0, 0, ST_OK, 0));
		plan.push_back(plan_row(OP_RMIN, 0, 1'b0, 0, ST_OK, 0));
		plan.push_back(plan_row(OP_QMAX, 0, 1'b0, 0, ST_OK, 0));
		plan.push_back(plan_row(OP_RMAX, 0, 1'b0, 0, ST_OK, 0));

		wait (arst_n);
		@(posedge clk);

		foreach (plan[i])
			send_word(plan[i].req, plan[i].typed, plan[i].want);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			case ((n / 60) % 3)
				0: insert_pct = 75;
				1: insert_pct = 20;
				default: insert_pct = 50;
			endcase
			no_idle = (n >= 300 && n < 420);
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			send_word(random_request(insert_pct), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("min_max_value_store_core_tb passed");
		else
			$display("min_max_value_store_core_tb failed");
		$finish;
	end

endmodule
